// File: sv/rfr_pkg.sv
`default_nettype none
package rfr_pkg;

    localparam int unsigned MAX_FRAME_LEN = 128;
    localparam int unsigned NDATA         = 19;
    localparam int unsigned IDX_W         = 5;

    localparam logic [7:0] HDR_FIRST     = 8'h5A;
    localparam logic [7:0] HDR_SECOND    = 8'hA5;
    localparam logic [7:0] MIN_LEN       = 8'd4;
    localparam logic [7:0] MAX_LEN       = 8'(MAX_FRAME_LEN);
    localparam logic [7:0] TYPE1_MIN_LEN = 8'd23;
    localparam logic [7:0] TYPE_FIELDS   = 8'd1;
    localparam logic [7:0] POS_TYPE      = 8'd3;
    localparam logic [7:0] POS_DATA      = 8'd4;
    localparam logic [7:0] POS_DATA_END  = 8'(4 + NDATA);

    localparam logic [IDX_W-1:0] IDX_ANALOG  = 5'd8;
    localparam logic [IDX_W-1:0] IDX_SWITCH  = 5'd11;
    localparam logic [IDX_W-1:0] IDX_COMMAND = 5'd17;
    localparam logic [IDX_W-1:0] IDX_LAST    = 5'(NDATA - 1);

    localparam logic [2:0] STATUS_FIELD   = 3'd0;
    localparam logic [2:0] STATUS_OTHER   = 3'd1;
    localparam logic [2:0] STATUS_XOR_ERR = 3'd2;
    localparam logic [2:0] STATUS_SUM_ERR = 3'd3;
    localparam logic [2:0] STATUS_BAD_LEN = 3'd4;

    localparam int unsigned HORN_BIT = 5;

    // floor(x / 255) for any 16-bit x whose quotient fits in 8 bits (x below 65280)
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    // floor(d * 255 / 250) = d + floor(d / 50), held at 255
    function automatic logic [7:0] analog_scale(input logic [7:0] d);
        logic [18:0] p;
        logic [8:0]  s;
        p = {11'd0, d} * 19'd1311;
        s = {1'b0, d} + {6'd0, p[18:16]};
        return s[8] ? 8'hFF : s[7:0];
    endfunction

endpackage
`default_nettype wire

// File: sv/remote_frame_receiver_core.sv
`default_nettype none
// Remote frame receiver.
// s_* channel: one received byte per transfer (s_tdata[7:0] = rx_byte).
// m_* channel: result items. Each frame gives one result, or nineteen field
//   results for a good frame of type 1; m_tlast marks the last of a frame.
// cfg_* channel: write of stick_full_scale; always ready, write only while idle.
// Frame bytes are parsed one per cycle: the block takes a byte every cycle
//   while it parses, as long as the output register is free or being drained.
// An error or other-type result shows on m_* in the cycle after the byte that ends
//   the frame. For a type-1 frame the payload sits in a 19-entry payload RAM
//   with registered read; each field goes through RAM read, scale multiply and
//   output load in turn, one field at a time, the load waiting for a free output
//   register; input is held off during the burst.
// When m_tready is low the finished result holds in the output register and
//   s_tready stays low until that result is taken; no byte is taken while a
//   result waits.
// Reset returns the parser to the header hunt, empties the output register and
//   sets stick_full_scale to 255. The payload RAM is not cleared; every entry
//   is written by a type-1 frame before it is read.
module remote_frame_receiver_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] field_value, [8] horn_on, rest zero
    output logic [15:0]      m_tuser,   // [2:0] status, [10:3] frame_type, [15:11] field_index
    output logic             m_tlast,   // last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data   // stick_full_scale
);
    import rfr_pkg::*;

    // Parser and burst sequencer states
    localparam logic [3:0] ST_HUNT1 = 4'd0;
    localparam logic [3:0] ST_HUNT2 = 4'd1;
    localparam logic [3:0] ST_LEN   = 4'd2;
    localparam logic [3:0] ST_BODY  = 4'd3;
    localparam logic [3:0] ST_XOR   = 4'd4;
    localparam logic [3:0] ST_SUM   = 4'd5;
    localparam logic [3:0] ST_RD    = 4'd6;
    localparam logic [3:0] ST_CALC  = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       pos_reg, pos_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       kind_reg, kind_next;
    logic [7:0]       fs_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // Payload RAM and read/scale pipeline
    logic [7:0]       payload_mem [NDATA];
    logic [7:0]       rdata_reg;
    logic [7:0]       data_reg;
    logic [15:0]      prod_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [7:0]       pos_inc;

    // Output register
    logic             out_valid_reg;
    logic [2:0]       status_reg;
    logic [7:0]       type_reg;
    logic [IDX_W-1:0] findex_reg;
    logic [7:0]       fvalue_reg;
    logic             horn_reg;
    logic             last_reg;

    logic             out_free;
    logic             in_xfer;
    logic             out_load;
    logic [2:0]       ld_status;
    logic [7:0]       ld_type;
    logic [IDX_W-1:0] ld_index;
    logic [7:0]       ld_value;
    logic             ld_horn;
    logic             ld_last;
    logic [7:0]       b;

    assign b         = s_tdata;
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg <= ST_SUM) && out_free;
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign pos_inc   = pos_reg + 8'd1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, horn_reg, fvalue_reg};
    assign m_tuser  = {findex_reg, type_reg, status_reg};
    assign m_tlast  = last_reg;

    // Store data bytes d0..d18 as they stream past
    assign mem_we    = in_xfer && (state_reg == ST_BODY)
                       && (pos_reg >= POS_DATA) && (pos_reg < POS_DATA_END);
    assign mem_waddr = IDX_W'(pos_reg - POS_DATA);

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        sum_next   = sum_reg;
        kind_next  = kind_reg;
        idx_next   = idx_reg;
        out_load   = 1'b0;
        ld_status  = STATUS_FIELD;
        ld_type    = 8'd0;
        ld_index   = '0;
        ld_value   = 8'd0;
        ld_horn    = 1'b0;
        ld_last    = 1'b1;

        case (state_reg)
            ST_HUNT1:
            begin
                if (in_xfer && b == HDR_FIRST)
                    state_next = ST_HUNT2;
            end
            ST_HUNT2:
            begin
                if (in_xfer)
                begin
                    if (b == HDR_SECOND)
                        state_next = ST_LEN;
                    else if (b != HDR_FIRST)
                        state_next = ST_HUNT1;
                end
            end
            ST_LEN:
            begin
                if (in_xfer)
                begin
                    if (b < MIN_LEN || b > MAX_LEN)
                    begin
                        out_load   = 1'b1;
                        ld_status  = STATUS_BAD_LEN;
                        state_next = ST_HUNT1;
                    end
                    else
                    begin
                        len_next   = b;
                        xor_next   = b;
                        sum_next   = b;
                        pos_next   = POS_TYPE;
                        state_next = ST_BODY;
                    end
                end
            end
            ST_BODY:
            begin
                if (in_xfer)
                begin
                    if (pos_reg == POS_TYPE)
                        kind_next = b;
                    if (pos_reg == POS_TYPE && b == TYPE_FIELDS && len_reg < TYPE1_MIN_LEN)
                    begin
                        out_load   = 1'b1;
                        ld_status  = STATUS_BAD_LEN;
                        state_next = ST_HUNT1;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ b;
                        sum_next = sum_reg + b;
                        pos_next = pos_inc;
                        if (pos_inc >= len_reg)
                            state_next = ST_XOR;
                    end
                end
            end
            ST_XOR:
            begin
                if (in_xfer)
                begin
                    if (b != xor_reg)
                    begin
                        out_load   = 1'b1;
                        ld_status  = STATUS_XOR_ERR;
                        state_next = ST_HUNT1;
                    end
                    else
                        state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (in_xfer)
                begin
                    if (b != sum_reg)
                    begin
                        out_load   = 1'b1;
                        ld_status  = STATUS_SUM_ERR;
                        state_next = ST_HUNT1;
                    end
                    else if (kind_reg != TYPE_FIELDS)
                    begin
                        out_load   = 1'b1;
                        ld_status  = STATUS_OTHER;
                        ld_type    = kind_reg;
                        state_next = ST_HUNT1;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
                state_next = ST_CALC;
            ST_CALC:
                state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    ld_status = STATUS_FIELD;
                    ld_type   = TYPE_FIELDS;
                    ld_index  = idx_reg;
                    if (idx_reg < IDX_ANALOG)
                        ld_value = div255(prod_reg);
                    else if (idx_reg < IDX_SWITCH)
                        ld_value = analog_scale(data_reg);
                    else
                        ld_value = data_reg;
                    ld_horn = (idx_reg == IDX_COMMAND) ? data_reg[HORN_BIT] : 1'b0;
                    ld_last = (idx_reg == IDX_LAST);
                    if (idx_reg == IDX_LAST)
                        state_next = ST_HUNT1;
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default:
                state_next = ST_HUNT1;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HUNT1;
            len_reg       <= 8'd0;
            pos_reg       <= 8'd0;
            xor_reg       <= 8'd0;
            sum_reg       <= 8'd0;
            kind_reg      <= 8'd0;
            idx_reg       <= '0;
            fs_reg        <= 8'hFF;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            xor_reg   <= xor_next;
            sum_reg   <= sum_next;
            kind_reg  <= kind_next;
            idx_reg   <= idx_next;
            if (cfg_valid && cfg_ready)
                fs_reg <= cfg_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload RAM: one write port from the parser, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            payload_mem[mem_waddr] <= b;
        if (state_reg == ST_RD)
            rdata_reg <= payload_mem[idx_reg];
    end

    // Scale stage: register the stick product before the divide-by-255 fixup
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CALC)
        begin
            data_reg <= rdata_reg;
            prod_reg <= 16'(rdata_reg) * 16'(fs_reg);
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= ld_status;
            type_reg   <= ld_type;
            findex_reg <= ld_index;
            fvalue_reg <= ld_value;
            horn_reg   <= ld_horn;
            last_reg   <= ld_last;
        end
    end

endmodule
`default_nettype wire

// File: tb/tb_remote_frame_receiver_core.sv
`timescale 1ns / 1ps

module tb_remote_frame_receiver_core;

    import rfr_pkg::*;

    // Longest quiet stretch that a correct run can show is the long receiver
    // hold (HOLD_CYCLES); allow several times that before calling it a hang.
    localparam int QUIET_LIMIT   = 3000;
    // Let a whole type-1 burst and some margin pass before touching the
    // register or ending the run.
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_BYTES   = 50;
    localparam int MAX_REPORTS   = 10;

    // One result as seen on the master side.
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] ftype;
        logic [4:0] idx;
        logic [7:0] val;
        logic       horn;
        logic       last;
    } field_result_t;

    // Row of the directed table; when typed is set, the error result that the
    // byte must raise is given right here instead of by the predictor.
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        logic [2:0] status;
    } stim_row_t;

    typedef enum logic [2:0] {
        SEEK_FIRST,
        SEEK_SECOND,
        TAKE_LENGTH,
        TAKE_BODY,
        TAKE_XOR,
        TAKE_SUM
    } rx_phase_t;

    typedef enum int {FAULT_NONE, FAULT_XOR, FAULT_SUM} frame_fault_t;
    typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_t;

    localparam stim_row_t DIRECTED [30] = '{
        // stray byte after a first header byte drops back to the hunt
        '{HDR_FIRST,  1'b0, STATUS_FIELD},
        '{8'h37,      1'b0, STATUS_FIELD},
        // repeated first header byte keeps waiting; length 3 is too short
        '{HDR_FIRST,  1'b0, STATUS_FIELD},
        '{HDR_FIRST,  1'b0, STATUS_FIELD},
        '{HDR_SECOND, 1'b0, STATUS_FIELD},
        '{8'h03,      1'b1, STATUS_BAD_LEN},
        // length one above the maximum
        '{HDR_FIRST,  1'b0, STATUS_FIELD},
        '{HDR_SECOND, 1'b0, STATUS_FIELD},
        '{8'h81,      1'b1, STATUS_BAD_LEN},
        // type 1 with a length that cannot hold all fields
        '{HDR_FIRST,  1'b0, STATUS_FIELD},
        '{HDR_SECOND, 1'b0, STATUS_FIELD},
        '{8'h16,      1'b0, STATUS_FIELD},
        '{TYPE_FIELDS, 1'b1, STATUS_BAD_LEN},
        // shortest good frame, type 7
        '{HDR_FIRST,  1'b0, STATUS_FIELD},
        '{HDR_SECOND, 1'b0, STATUS_FIELD},
        '{8'h04,      1'b0, STATUS_FIELD},
        '{8'h07,      1'b0, STATUS_FIELD},
        '{8'h03,      1'b0, STATUS_FIELD},
        '{8'h0B,      1'b0, STATUS_FIELD},
        // bad xor byte
        '{HDR_FIRST,  1'b0, STATUS_FIELD},
        '{HDR_SECOND, 1'b0, STATUS_FIELD},
        '{8'h04,      1'b0, STATUS_FIELD},
        '{8'hFF,      1'b0, STATUS_FIELD},
        '{8'h00,      1'b1, STATUS_XOR_ERR},
        // good xor, bad sum
        '{HDR_FIRST,  1'b0, STATUS_FIELD},
        '{HDR_SECOND, 1'b0, STATUS_FIELD},
        '{8'h04,      1'b0, STATUS_FIELD},
        '{8'h00,      1'b0, STATUS_FIELD},
        '{8'h04,      1'b0, STATUS_FIELD},
        '{8'h00,      1'b1, STATUS_SUM_ERR}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;      // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;              // [7:0] field_value, [8] horn_on
    logic [15:0] m_tuser;              // [2:0] status, [10:3] frame_type, [15:11] field_index
    logic        m_tlast;              // last
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'h00;     // stick_full_scale

    // Predictor state: a private copy of the parser and of the register.
    rx_phase_t   rx_phase = SEEK_FIRST;
    logic [7:0]  want_len = 8'h00;
    logic [7:0]  body_pos = 8'h00;
    logic [7:0]  run_xor = 8'h00;
    logic [7:0]  run_sum = 8'h00;
    logic [7:0]  frame_type_seen = 8'h00;
    logic [7:0]  payload [NDATA];
    logic [7:0]  full_scale = 8'hFF;

    field_result_t pending_results [$];
    logic [7:0]    frame_bytes [$];
    field_result_t seen_result;
    field_result_t want_result;

    int mismatches = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int phase_bytes = 0;

    remote_frame_receiver_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Drop the frame, log an error result and go back to the header hunt.
    function automatic void reject_frame(input logic [2:0] status);
        pending_results.push_back(field_result_t'{status, 8'h00, 5'd0, 8'h00, 1'b0, 1'b1});
        rx_phase = SEEK_FIRST;
    endfunction

    // Advance the parser by one received byte; queue every result it raises.
    function automatic void parse_rx_byte(input logic [7:0] b);
        field_result_t r;
        logic [15:0]   scaled;
        case (rx_phase)
            SEEK_FIRST:
                if (b == HDR_FIRST)
                    rx_phase = SEEK_SECOND;
            SEEK_SECOND:
                if (b == HDR_SECOND)
                    rx_phase = TAKE_LENGTH;
                else if (b != HDR_FIRST)
                    rx_phase = SEEK_FIRST;
            TAKE_LENGTH:
                if (b < MIN_LEN || b > MAX_LEN)
                    reject_frame(STATUS_BAD_LEN);
                else
                begin
                    want_len = b;
                    run_xor  = b;
                    run_sum  = b;
                    body_pos = POS_TYPE;
                    rx_phase = TAKE_BODY;
                end
            TAKE_BODY:
                if (body_pos == POS_TYPE && b == TYPE_FIELDS && want_len < TYPE1_MIN_LEN)
                begin
                    frame_type_seen = b;
                    reject_frame(STATUS_BAD_LEN);
                end
                else
                begin
                    if (body_pos == POS_TYPE)
                        frame_type_seen = b;
                    else if (body_pos < POS_DATA_END)
                        payload[body_pos - POS_DATA] = b;
                    run_xor  = run_xor ^ b;
                    run_sum  = run_sum + b;
                    body_pos = body_pos + 8'd1;
                    if (body_pos >= want_len)
                        rx_phase = TAKE_XOR;
                end
            TAKE_XOR:
                if (b != run_xor)
                    reject_frame(STATUS_XOR_ERR);
                else
                    rx_phase = TAKE_SUM;
            TAKE_SUM:
                if (b != run_sum)
                    reject_frame(STATUS_SUM_ERR);
                else
                begin
                    rx_phase = SEEK_FIRST;
                    if (frame_type_seen != TYPE_FIELDS)
                        pending_results.push_back(field_result_t'{STATUS_OTHER,
                            frame_type_seen, 5'd0, 8'h00, 1'b0, 1'b1});
                    else
                        for (int i = 0; i < NDATA; i++)
                        begin
                            // sticks scale to full_scale/255, analog to 255/250
                            // held at 255, the rest pass through
                            if (i < IDX_ANALOG)
                                scaled = 16'(payload[i]) * 16'(full_scale) / 16'd255;
                            else if (i < IDX_SWITCH)
                            begin
                                scaled = 16'(payload[i]) * 16'd255 / 16'd250;
                                if (scaled > 16'd255)
                                    scaled = 16'd255;
                            end
                            else
                                scaled = 16'(payload[i]);
                            r.status = STATUS_FIELD;
                            r.ftype  = TYPE_FIELDS;
                            r.idx    = 5'(i);
                            r.val    = scaled[7:0];
                            r.horn   = (i == IDX_COMMAND) ? payload[i][HORN_BIT] : 1'b0;
                            r.last   = (i == IDX_LAST);
                            pending_results.push_back(r);
                        end
                end
            default:
                rx_phase = SEEK_FIRST;
        endcase
    endfunction

    // Offer one byte, idling first at the current rate, and hold it until
    // the transfer; then predict what it causes.
    task automatic push_rx_byte(input logic [7:0] b, input logic typed,
                                input logic [2:0] typed_status);
        int unsigned n0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        n0 = pending_results.size();
        parse_rx_byte(b);
        if (typed)
        begin
            while (pending_results.size() > n0)
                void'(pending_results.pop_back());
            pending_results.push_back(field_result_t'{typed_status, 8'h00, 5'd0,
                                                      8'h00, 1'b0, 1'b1});
        end
        phase_bytes++;
    endtask

    task automatic send_frame_bytes();
        while (frame_bytes.size() != 0)
            push_rx_byte(frame_bytes.pop_front(), 1'b0, STATUS_FIELD);
    endtask

    // Append a complete frame, optionally with a corrupt xor or sum byte.
    // A bad xor ends the frame, since the block drops back to the hunt there.
    function automatic void build_frame(input frame_fault_t fault, input int unsigned len,
                                        input logic [7:0] ftype, input fill_t fill);
        logic [7:0] x;
        logic [7:0] s;
        logic [7:0] d;
        x = 8'(len) ^ ftype;
        s = 8'(len) + ftype;
        frame_bytes.push_back(HDR_FIRST);
        frame_bytes.push_back(HDR_SECOND);
        frame_bytes.push_back(8'(len));
        frame_bytes.push_back(ftype);
        for (int unsigned p = POS_DATA; p < len; p++)
        begin
            if (fill == FILL_ZEROS)
                d = 8'h00;
            else if (fill == FILL_ONES)
                d = 8'hFF;
            else if ($urandom_range(0, 9) == 0)
                case ($urandom_range(0, 3))
                    0:       d = 8'h00;
                    1:       d = 8'hFF;
                    2:       d = 8'($urandom_range(250, 255));
                    default: d = HDR_FIRST;
                endcase
            else
                d = 8'($urandom);
            frame_bytes.push_back(d);
            x = x ^ d;
            s = s + d;
        end
        if (fault == FAULT_XOR)
        begin
            frame_bytes.push_back(x ^ 8'($urandom_range(1, 255)));
            return;
        end
        frame_bytes.push_back(x);
        frame_bytes.push_back(fault == FAULT_SUM ? s ^ 8'($urandom_range(1, 255)) : s);
    endfunction

    // Pick one random sequence: mostly good frames, some corrupt ones and noise.
    function automatic void queue_random_frame();
        int unsigned  pick;
        int unsigned  len;
        logic [7:0]   ftype;
        frame_fault_t fault;
        pick = $urandom_range(0, 99);
        fault = (pick < 65) ? FAULT_NONE : (pick < 72) ? FAULT_XOR : FAULT_SUM;
        if (pick < 79)
        begin
            if (pick < 45 || (pick >= 65 && $urandom_range(0, 1) == 1))
            begin
                ftype = TYPE_FIELDS;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(TYPE1_MIN_LEN, MAX_LEN)
                                                  : $urandom_range(TYPE1_MIN_LEN, 30);
            end
            else
            begin
                ftype = 8'($urandom);
                if (ftype == TYPE_FIELDS)
                    ftype = 8'h00;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(MIN_LEN, MAX_LEN)
                                                  : $urandom_range(MIN_LEN, 20);
            end
            build_frame(fault, len, ftype, FILL_RANDOM);
        end
        else if (pick < 85)
        begin
            // length out of range on either side
            frame_bytes.push_back(HDR_FIRST);
            frame_bytes.push_back(HDR_SECOND);
            frame_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, MIN_LEN - 1))
                                                       : 8'($urandom_range(MAX_LEN + 1, 255)));
        end
        else if (pick < 90)
        begin
            // type 1 that is too short
            frame_bytes.push_back(HDR_FIRST);
            frame_bytes.push_back(HDR_SECOND);
            frame_bytes.push_back(8'($urandom_range(MIN_LEN, TYPE1_MIN_LEN - 1)));
            frame_bytes.push_back(TYPE_FIELDS);
        end
        else
            repeat ($urandom_range(1, 4))
                frame_bytes.push_back($urandom_range(0, 2) == 0 ? HDR_FIRST : 8'($urandom));
    endfunction

    // Write the full-scale register once the block has gone quiet.
    task automatic write_full_scale(input logic [7:0] value);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        full_scale = value;
    endtask

    // Receiver: stall at the current rate, or hold off for a long stretch
    // whenever one is requested, so that the block backs up into its input.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare every result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            seen_result = field_result_t'{m_tuser[2:0], m_tuser[10:3], m_tuser[15:11],
                                          m_tdata[7:0], m_tdata[8], m_tlast};
            if (pending_results.size() == 0)
            begin
                want_result = '0;
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected st=%0d ty=%h idx=%0d val=%h horn=%b last=%b",
                             $time, seen_result.status, seen_result.ftype, seen_result.idx,
                             seen_result.val, seen_result.horn, seen_result.last);
            end
            else
            begin
                want_result = pending_results.pop_front();
                if (seen_result !== want_result)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: expected st=%0d ty=%h idx=%0d val=%h horn=%b last=%b",
                                 $time, want_result.status, want_result.ftype,
                                 want_result.idx, want_result.val, want_result.horn,
                                 want_result.last);
                        $display("%0t:   actual st=%0d ty=%h idx=%0d val=%h horn=%b last=%b",
                                 $time, seen_result.status, seen_result.ftype,
                                 seen_result.idx, seen_result.val, seen_result.horn,
                                 seen_result.last);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL remote_frame_receiver_core");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: resync, range, type, xor and sum errors, the shortest frame.
        // The sender keeps offering straight into the first phase.
        foreach (DIRECTED[k])
            push_rx_byte(DIRECTED[k].rx, DIRECTED[k].typed, DIRECTED[k].status);

        // Random phases: idle pattern and register setting change per phase.
        // The first phase keeps the reset full scale and starts with a long
        // receiver hold and frames at the data extremes.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                1: write_full_scale(8'd1);
                2: write_full_scale(8'($urandom_range(2, 254)));
                3: write_full_scale(8'd255);
                default: ;
            endcase
            send_idle_pct  = (ph == 1) ? 47 : (ph == 3) ? 31 : 0;
            recv_stall_pct = (ph == 2) ? 47 : (ph == 3) ? 31 : 0;
            phase_bytes = 0;
            if (ph == 0)
            begin
                hold_requests++;
                build_frame(FAULT_NONE, TYPE1_MIN_LEN, TYPE_FIELDS, FILL_ONES);
                build_frame(FAULT_NONE, TYPE1_MIN_LEN, TYPE_FIELDS, FILL_ZEROS);
                build_frame(FAULT_NONE, MAX_LEN, 8'hFF, FILL_RANDOM);
                send_frame_bytes();
            end
            while (phase_bytes < PHASE_BYTES)
            begin
                queue_random_frame();
                send_frame_bytes();
            end
            s_tvalid <= 1'b0;
        end

        // Drain: every predicted result must arrive, then nothing more.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS remote_frame_receiver_core");
        else
            $display("FAIL remote_frame_receiver_core");
        $finish;
    end

endmodule
